[rtl/core/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg: shared definitions of the merge sort engine
// Data width, default capacity and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned DataW              = 32;
  localparam int unsigned MaxElementsDefault = 64;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pair_init;
    logic rd_a;
    logic cap_a;
    logic cap_b;
    logic take;
    logic fill;
    logic next_pair;
    logic next_pass;
    logic emit_rd;
    logic emit_cap;
    logic run_clear;
  } mse_cmd_t;

  typedef struct packed {
    logic multi;
    logic b_lt_hi;
    logic k_lt_hi;
    logic next_lo_lt_n;
    logic w2_lt_n;
    logic out_done;
    logic out_end;
    logic out_busy;
  } mse_sts_t;

endpackage

[rtl/core/mse_in_if.sv]
// ----------------------------------------------------------------------------
// mse_in_if: input channel of the merge sort engine
// One word carries one array element and the flag that ends the array.
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

[rtl/core/mse_out_if.sv]
// ----------------------------------------------------------------------------
// mse_out_if: output channel of the merge sort engine
// One word carries one sorted element with its end and overflow flags.
// ----------------------------------------------------------------------------
interface mse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               end_of_run;
  logic               overflow;

  modport source (output valid, output sorted_value, output end_of_run, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input end_of_run, input overflow,
                output ready);
endinterface

[rtl/core/merge_sort_engine.sv]
// ----------------------------------------------------------------------------
// merge_sort_engine: collecting merge sorter for signed 32-bit words
//
// Input channel in_i takes one element per word; the word flagged last
// closes the array and starts the sort. Up to MaxElements elements are
// kept; further words are dropped and every output word of that run then
// carries overflow. Loading takes one word per cycle.
// The sort runs bottom-up merge passes between two halves of one RAM with
// a single read and a single write port. The sorted words then leave
// out_o in ascending order, each only after the receiver has taken the
// one before, end_of_run on the last. A stalled receiver holds the output
// register and the sequencer waits; no new input is taken until the final
// word of the run has gone.
// Reset empties the run and the output register; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module merge_sort_engine
  import mse_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mse_in_if.sink           in_i,
  mse_out_if.source        out_o
);

  mse_cmd_t cmd;
  mse_sts_t sts;

  mse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mse_datapath #(
    .MaxElements (MaxElements)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_value_i     (in_i.value),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_value_o    (out_o.sorted_value),
    .out_end_o      (out_o.end_of_run),
    .out_overflow_o (out_o.overflow)
  );

endmodule

[rtl/core/mse_ram.sv]
// ----------------------------------------------------------------------------
// mse_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mse_ram
  import mse_pkg::*;
#(
  parameter int unsigned Width = DataW,
  parameter int unsigned Depth = 2 * MaxElementsDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mse_datapath.sv]
// ----------------------------------------------------------------------------
// mse_datapath: storage, run bookkeeping and merge datapath
// Holds the element store with its scratch half, the pass and run
// counters, the two run heads and the output register.
// ----------------------------------------------------------------------------
module mse_datapath
  import mse_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mse_cmd_t                cmd_i,
  output mse_sts_t                sts_o,
  input  logic signed [DataW-1:0] in_value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [DataW-1:0] out_value_o,
  output logic                    out_end_o,
  output logic                    out_overflow_o
);

  localparam int unsigned CntW  = $clog2(MaxElements + 1);
  localparam int unsigned IdxW  = $clog2(MaxElements + 1) + 3;
  localparam int unsigned Depth = 2 * MaxElements;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [CntW-1:0]         count_q, count_d;
  logic                    dropped_q, dropped_d;
  logic                    src_q, src_d;
  logic [IdxW-1:0]         width_q, width_d;
  logic [IdxW-1:0]         lo_q, lo_d;
  logic [IdxW-1:0]         mid_q, mid_d;
  logic [IdxW-1:0]         hi_q, hi_d;
  logic [IdxW-1:0]         a_q, a_d;
  logic [IdxW-1:0]         b_q, b_d;
  logic [IdxW-1:0]         k_q, k_d;
  logic                    fill_a_q, fill_a_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] head_a_q, head_b_q;
  logic signed [DataW-1:0] out_value_q;
  logic                    out_end_q;

  logic [IdxW-1:0]  n_ext;
  logic [IdxW-1:0]  lo_plus_w, lo_plus_2w, width_x2;
  logic [IdxW-1:0]  a_inc, b_inc, k_inc;
  logic             take_a;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  function automatic logic [AddrW-1:0] addr_of(input logic sel, input logic [IdxW-1:0] off);
    logic [AddrW-1:0] base;
    base = sel ? AddrW'(MaxElements) : '0;
    return base + off[AddrW-1:0];
  endfunction

  assign n_ext      = IdxW'(count_q);
  assign width_x2   = width_q << 1;
  assign lo_plus_w  = lo_q + width_q;
  assign lo_plus_2w = lo_q + width_x2;
  assign a_inc      = a_q + IdxW'(1);
  assign b_inc      = b_q + IdxW'(1);
  assign k_inc      = k_q + IdxW'(1);
  assign take_a     = (a_q < mid_q) && (!(b_q < hi_q) || (head_a_q <= head_b_q));

  always_comb begin
    sts_o.multi        = count_q > CntW'(1);
    sts_o.b_lt_hi      = b_q < hi_q;
    sts_o.k_lt_hi      = k_q < hi_q;
    sts_o.next_lo_lt_n = lo_plus_2w < n_ext;
    sts_o.w2_lt_n      = width_x2 < n_ext;
    sts_o.out_done     = out_valid_q & out_ready_i;
    sts_o.out_end      = out_end_q;
    sts_o.out_busy     = out_valid_q;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = in_value_i;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.load && (count_q < CntW'(MaxElements))) begin
      ram_we    = 1'b1;
      ram_waddr = AddrW'(count_q);
    end
    if (cmd_i.take) begin
      ram_we    = 1'b1;
      ram_waddr = addr_of(~src_q, k_q);
      ram_wdata = take_a ? head_a_q : head_b_q;
      if (take_a) begin
        ram_re    = a_inc < mid_q;
        ram_raddr = addr_of(src_q, a_inc);
      end else begin
        ram_re    = b_inc < hi_q;
        ram_raddr = addr_of(src_q, b_inc);
      end
    end
    if (cmd_i.rd_a) begin
      ram_re    = 1'b1;
      ram_raddr = addr_of(src_q, a_q);
    end
    if (cmd_i.cap_a) begin
      ram_re    = b_q < hi_q;
      ram_raddr = addr_of(src_q, b_q);
    end
    if (cmd_i.emit_rd) begin
      ram_re    = 1'b1;
      ram_raddr = addr_of(src_q, k_q);
    end
  end

  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    src_d       = src_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    fill_a_d    = fill_a_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      if (count_q < CntW'(MaxElements)) begin
        count_d = count_q + CntW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.sort_init) begin
      width_d = IdxW'(1);
      lo_d    = '0;
      src_d   = 1'b0;
      k_d     = '0;
    end
    if (cmd_i.pair_init) begin
      mid_d = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
      hi_d  = (lo_plus_2w < n_ext) ? lo_plus_2w : n_ext;
      a_d   = lo_q;
      b_d   = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
      k_d   = lo_q;
    end
    if (cmd_i.take) begin
      k_d      = k_inc;
      fill_a_d = take_a;
      if (take_a) begin
        a_d = a_inc;
      end else begin
        b_d = b_inc;
      end
    end
    if (cmd_i.next_pair) begin
      lo_d = lo_plus_2w;
    end
    if (cmd_i.next_pass) begin
      width_d = width_x2;
      lo_d    = '0;
      src_d   = ~src_q;
      k_d     = '0;
    end
    if (cmd_i.emit_cap) begin
      k_d         = k_inc;
      out_valid_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.run_clear) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      src_q       <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      fill_a_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      src_q       <= src_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      a_q         <= a_d;
      b_q         <= b_d;
      k_q         <= k_d;
      fill_a_q    <= fill_a_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a || (cmd_i.fill && fill_a_q)) begin
      head_a_q <= $signed(ram_rdata);
    end
    if (cmd_i.cap_b || (cmd_i.fill && !fill_a_q)) begin
      head_b_q <= $signed(ram_rdata);
    end
    if (cmd_i.emit_cap) begin
      out_value_q <= $signed(ram_rdata);
      out_end_q   <= k_inc == n_ext;
    end
  end

  mse_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_end_o      = out_end_q;
  assign out_overflow_o = dropped_q;

`ifndef NO_ASSERTIONS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxElements))
    else $error("Element count exceeds the capacity.");

  a_take_in_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> (k_q < hi_q) && ((a_q < mid_q) || (b_q < hi_q)))
    else $error("Merge step issued with no element left in the pair.");

  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_cap |-> !out_valid_q)
    else $error("Output word overwritten before it was taken.");
`endif

endmodule

[rtl/core/mse_ctrl.sv]
// ----------------------------------------------------------------------------
// mse_ctrl: sequencer of the merge sort engine
// Steps the datapath through loading, the bottom-up merge passes and the
// emission of the sorted run.
// ----------------------------------------------------------------------------
module mse_ctrl
  import mse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  mse_sts_t sts_i,
  output mse_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    ST_LOAD      = 11'b000_0000_0001,
    ST_START     = 11'b000_0000_0010,
    ST_PAIR      = 11'b000_0000_0100,
    ST_RDA       = 11'b000_0000_1000,
    ST_CAPA      = 11'b000_0001_0000,
    ST_CAPB      = 11'b000_0010_0000,
    ST_MERGE     = 11'b000_0100_0000,
    ST_FILL      = 11'b000_1000_0000,
    ST_EMIT_RD   = 11'b001_0000_0000,
    ST_EMIT_CAP  = 11'b010_0000_0000,
    ST_EMIT_WAIT = 11'b100_0000_0000
  } mse_state_e;

  mse_state_e state_q, state_d;

  assign in_ready_o = state_q == ST_LOAD;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.sort_init = 1'b1;
        state_d = sts_i.multi ? ST_PAIR : ST_EMIT_RD;
      end
      ST_PAIR: begin
        cmd_o.pair_init = 1'b1;
        state_d = ST_RDA;
      end
      ST_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d = ST_CAPA;
      end
      ST_CAPA: begin
        cmd_o.cap_a = 1'b1;
        state_d = sts_i.b_lt_hi ? ST_CAPB : ST_MERGE;
      end
      ST_CAPB: begin
        cmd_o.cap_b = 1'b1;
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (sts_i.k_lt_hi) begin
          cmd_o.take = 1'b1;
          state_d = ST_FILL;
        end else if (sts_i.next_lo_lt_n) begin
          cmd_o.next_pair = 1'b1;
          state_d = ST_PAIR;
        end else begin
          cmd_o.next_pass = 1'b1;
          state_d = sts_i.w2_lt_n ? ST_PAIR : ST_EMIT_RD;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d = ST_MERGE;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        cmd_o.emit_cap = 1'b1;
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (sts_i.out_done) begin
          if (sts_i.out_end) begin
            cmd_o.run_clear = 1'b1;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !sts_i.out_busy)
    else $error("Input accepted while an output word is pending.");

  a_emit_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_WAIT) && sts_i.out_done && !sts_i.out_end
      |=> state_q == ST_EMIT_RD)
    else $error("Emission stopped before the final word.");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("Sequencer state is not one-hot.");
`endif

endmodule

[verif/tb_merge_sort_engine.sv]
// ----------------------------------------------------------------------------
// tb_merge_sort_engine: self-checking bench for the merge sort engine
// Feeds arrays of signed words through the input channel and rebuilds the
// sorted output of every run with a bottom-up merge of its own. Each output
// word is checked field by field against the oldest pending expectation.
// Both channels idle at random. The stimulus covers single-element,
// duplicate and extreme-value arrays, a run that fills the store exactly,
// and one that overflows it.
// ----------------------------------------------------------------------------
module tb_merge_sort_engine;
  import mse_pkg::*;

  localparam int Cap = MaxElementsDefault;

  typedef logic signed [DataW-1:0] word_t;

  localparam word_t WordMax = 32'sh7fffffff;
  localparam word_t WordMin = 32'sh80000000;

  typedef struct {
    word_t value;
    logic  last;
    logic  drain_first;
    logic  steady;
  } element_word_t;

  typedef struct {
    word_t value;
    logic  last_word;
    logic  ovf;
  } sorted_word_t;

  logic clk;
  logic rst_n;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  merge_sort_engine #(
    .MaxElements(Cap)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  element_word_t pending_words[$];
  sorted_word_t  sorted_due[$];
  element_word_t next_word;
  sorted_word_t  due;

  word_t held[Cap];
  word_t work_src[Cap];
  word_t work_dst[Cap];
  int    held_count;
  logic  drop_seen;
  int    span, lo, mid, hi, ia, ib, k;

  int  failures;
  int  words_checked;
  int  runs_done;
  int  ovf_runs;
  int  largest_run;
  logic mark_drain;
  logic mark_steady;
  logic sink_steady;

  assign sink_steady = (words_checked >= 30) && (words_checked < 110);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic add_word(input word_t value, input logic last);
    element_word_t w;
    w.value       = value;
    w.last        = last;
    w.drain_first = mark_drain;
    w.steady      = mark_steady;
    mark_drain    = 1'b0;
    pending_words.push_back(w);
  endtask

  task automatic add_random_run(input int len);
    int    mode;
    word_t v;
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        v = $urandom;
      end else if (mode < 8) begin
        v = $signed($urandom_range(0, 15)) - 8;
      end else if (mode == 8) begin
        v = $urandom_range(0, 1) ? WordMax : WordMin;
      end else begin
        v = $urandom_range(0, 1) ? WordMax - $urandom_range(0, 3)
                                 : WordMin + $urandom_range(0, 3);
      end
      add_word(v, i == len - 1);
    end
  endtask

  // Sender: a word leaves the queue only when the previous one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_words[0].drain_first &&
                   (in_ch.valid || sorted_due.size() != 0 || out_ch.valid)) begin
        in_ch.valid <= 1'b0;
      end else if (!pending_words[0].steady && $urandom_range(0, 99) < 22) begin
        in_ch.valid <= 1'b0;
      end else begin
        next_word = pending_words.pop_front();
        in_ch.value <= next_word.value;
        in_ch.last  <= next_word.last;
        in_ch.valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= sink_steady || ($urandom_range(0, 99) >= 22);
    end
  end

  // Checks each output word, then folds each accepted input word into the
  // running array; a word flagged last sorts the array and queues the results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected word: value %0d end_of_run %0b overflow %0b",
                   $time, out_ch.sorted_value, out_ch.end_of_run, out_ch.overflow);
          failures++;
        end else begin
          due = sorted_due.pop_front();
          if (out_ch.sorted_value !== due.value) begin
            $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                     $time, due.value, out_ch.sorted_value);
            failures++;
          end
          if (out_ch.end_of_run !== due.last_word) begin
            $display("%0t: end_of_run mismatch: expected %0b, actual %0b",
                     $time, due.last_word, out_ch.end_of_run);
            failures++;
          end
          if (out_ch.overflow !== due.ovf) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, due.ovf, out_ch.overflow);
            failures++;
          end
          words_checked++;
          if (due.last_word) begin
            runs_done++;
            if (due.ovf) begin
              ovf_runs++;
            end
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (held_count < Cap) begin
          held[held_count] = in_ch.value;
          held_count++;
        end else begin
          drop_seen = 1'b1;
        end
        if (in_ch.last) begin
          for (k = 0; k < held_count; k++) begin
            work_src[k] = held[k];
          end
          for (span = 1; span < held_count; span = span * 2) begin
            for (lo = 0; lo < held_count; lo = lo + 2 * span) begin
              mid = (lo + span < held_count) ? lo + span : held_count;
              hi  = (lo + 2 * span < held_count) ? lo + 2 * span : held_count;
              ia  = lo;
              ib  = mid;
              for (k = lo; k < hi; k++) begin
                if (ia < mid && (ib >= hi || work_src[ia] <= work_src[ib])) begin
                  work_dst[k] = work_src[ia];
                  ia++;
                end else begin
                  work_dst[k] = work_src[ib];
                  ib++;
                end
              end
            end
            for (k = 0; k < held_count; k++) begin
              work_src[k] = work_dst[k];
            end
          end
          for (k = 0; k < held_count; k++) begin
            due.value     = work_src[k];
            due.last_word = (k == held_count - 1);
            due.ovf       = drop_seen;
            sorted_due.push_back(due);
          end
          if (held_count > largest_run) begin
            largest_run = held_count;
          end
          held_count = 0;
          drop_seen  = 1'b0;
        end
      end
    end
  end

  initial begin
    int random_count;
    int roll;
    int len;
    logic placed_full;
    logic placed_ovf;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    held_count    = 0;
    drop_seen     = 1'b0;
    failures      = 0;
    words_checked = 0;
    runs_done     = 0;
    ovf_runs      = 0;
    largest_run   = 0;
    mark_drain    = 1'b0;
    mark_steady   = 1'b0;

    // A single element, then the extremes with INT_MAX repeated at the end.
    add_word(WordMin, 1'b1);
    add_word(WordMax, 1'b0);
    add_word(WordMin, 1'b0);
    add_word(0, 1'b0);
    add_word(-1, 1'b0);
    add_word(1, 1'b0);
    add_word(WordMax, 1'b1);
    add_word(5, 1'b0);
    add_word(5, 1'b1);
    for (int i = 3; i >= -3; i--) begin
      add_word(i, i == -3);
    end
    add_word(WordMax, 1'b0);
    add_word(WordMin + 1, 1'b0);
    add_word(32'shffffffff, 1'b1);

    // The random part first waits for the directed runs to drain. A full
    // run comes first, then short runs, then the overflowing run.
    mark_drain   = 1'b1;
    random_count = 0;
    placed_full  = 1'b0;
    placed_ovf   = 1'b0;
    while (!placed_ovf) begin
      roll = $urandom_range(0, 9);
      if (!placed_full) begin
        len         = Cap;
        placed_full = 1'b1;
        mark_steady = 1'b1;
      end else if (random_count >= Cap + 8) begin
        len        = Cap + 2;
        placed_ovf = 1'b1;
        mark_drain = 1'b1;
      end else if (roll < 8) begin
        len = $urandom_range(1, 6);
      end else begin
        len = $urandom_range(7, 12);
      end
      add_random_run(len);
      mark_steady  = 1'b0;
      random_count = random_count + len;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid || sorted_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);

    $display("Checked %0d sorted words in %0d runs, the largest holding %0d words;",
             words_checked, runs_done, largest_run);
    $display("%0d runs overflowed the store.", ovf_runs);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d words outstanding.", sorted_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/core/mse_pkg.sv
rtl/core/mse_in_if.sv
rtl/core/mse_out_if.sv
rtl/core/mse_ram.sv
rtl/core/mse_datapath.sv
rtl/core/mse_ctrl.sv
rtl/core/merge_sort_engine.sv
verif/tb_merge_sort_engine.sv
